/* src/tccw_pkg.sv */
// Shared constants and request/result types for the text console character writer.
package tccw_pkg;

  // Default screen geometry.
  localparam int unsigned ROWS_DEFAULT    = 25;
  localparam int unsigned COLUMNS_DEFAULT = 80;

  // Fixed port field widths.
  localparam int unsigned ADDR_IN_W    = 11;
  localparam int unsigned CURSOR_OUT_W = 11;

  // Control and fill characters.
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // One incoming request.
  typedef struct packed {
    logic                 command;
    logic [7:0]           byte_value;
    logic [ADDR_IN_W-1:0] cell_address;
  } req_t;

  // One outgoing result.
  typedef struct packed {
    logic [CURSOR_OUT_W-1:0] cursor_position;
    logic [7:0]              read_character;
    logic                    scrolled;
  } res_t;

endpackage

/* src/tccw_ram.sv */
// Character store: one write port and one read port with registered read data.
module tccw_ram
  import tccw_pkg::*;
#(
  parameter int unsigned DEPTH = ROWS_DEFAULT * COLUMNS_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data available in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/tccw_addr_unit.sv */
// Shared address adder with an end-of-screen compare.
module tccw_addr_unit
  import tccw_pkg::*;
#(
  parameter int unsigned W     = 11,
  parameter int unsigned LIMIT = ROWS_DEFAULT * COLUMNS_DEFAULT
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] sum,
  output logic         past_end
);

  // Modulo add, so adding all ones steps back by one.
  assign sum      = a + b;
  assign past_end = (sum >= W'(LIMIT));

endmodule

/* src/tccw_engine.sv */
// Sequencer for cursor moves, cell reads, scrolling and the reset clearing pass.
module tccw_engine
  import tccw_pkg::*;
#(
  parameter int unsigned ROWS    = ROWS_DEFAULT,
  parameter int unsigned COLUMNS = COLUMNS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic ready,
  output logic res_valid,
  output res_t res,
  input  logic res_take
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(CELLS + 1);
  localparam int unsigned COLW  = $clog2(COLUMNS);

  localparam logic [AW-1:0]   LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0]   COPY_LAST  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0]   BOTTOM_ROW = AW'(CELLS - COLUMNS);
  localparam logic [CW-1:0]   SCROLL_CUR = CW'(CELLS - COLUMNS);
  localparam logic [COLW-1:0] COL_LAST   = COLW'(COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_RD, ST_COPY, ST_DRAIN, ST_BLANK, ST_FINISH
  } state_t;

  state_t          state, state_next;
  logic [AW-1:0]   idx, idx_next;
  logic            wr_pend, wr_pend_next;
  logic [AW-1:0]   wr_addr, wr_addr_next;
  logic [CW-1:0]   cursor, cursor_next;
  logic [CW-1:0]   rowstart, rowstart_next;
  logic [COLW-1:0] col, col_next;
  req_t            req_q, req_q_next;
  res_t            res_next;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;
  logic [AW-1:0]   raddr;
  logic [7:0]      rdata;
  logic [CW-1:0]   op_a, op_b, sum;
  logic            past_end;
  logic            rd_in_range;

  tccw_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tccw_addr_unit #(
    .W     (CW),
    .LIMIT (CELLS)
  ) u_addr (
    .a        (op_a),
    .b        (op_b),
    .sum      (sum),
    .past_end (past_end)
  );

  assign ready       = (state == ST_IDLE);
  assign res_valid   = (state == ST_FINISH);
  assign rd_in_range = (32'(req_q.cell_address) < 32'(CELLS));

  // Operand selection for the shared adder.
  always_comb begin
    op_a = cursor;
    op_b = '0;
    case (state)
      ST_EXEC: begin
        case (req_q.byte_value)
          CH_NEWLINE: begin
            op_a = rowstart;
            op_b = CW'(COLUMNS);
          end
          CH_RETURN: begin
            op_a = rowstart;
          end
          CH_BACKSPACE: begin
            op_b = (col != '0) ? '1 : '0;
          end
          default: begin
            op_b = CW'(1);
          end
        endcase
      end
      ST_COPY: begin
        op_a = CW'(idx);
        op_b = CW'(COLUMNS);
      end
      default: begin
        op_a = cursor;
      end
    endcase
  end

  // Sequencer next state, store access and cursor update.
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    wr_pend_next  = wr_pend;
    wr_addr_next  = wr_addr;
    cursor_next   = cursor;
    rowstart_next = rowstart;
    col_next      = col;
    req_q_next    = req_q;
    res_next      = res;
    we            = 1'b0;
    waddr         = idx;
    wdata         = CH_SPACE;
    raddr         = AW'(req.cell_address);

    case (state)
      // Fill the whole store with spaces after reset.
      ST_CLEAR: begin
        we = 1'b1;
        if (idx == LAST_CELL) begin
          idx_next   = '0;
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end

      // Take a request; a read address goes to the store right away.
      ST_IDLE: begin
        if (start) begin
          req_q_next = req;
          state_next = (req.command == CMD_READ) ? ST_RD : ST_EXEC;
        end
      end

      // Read data is back from the store.
      ST_RD: begin
        res_next.cursor_position = CURSOR_OUT_W'(cursor);
        res_next.read_character  = rd_in_range ? rdata : CH_SPACE;
        res_next.scrolled        = 1'b0;
        state_next               = ST_FINISH;
      end

      // Interpret one byte and move the cursor.
      ST_EXEC: begin
        case (req_q.byte_value)
          CH_NEWLINE: begin
            cursor_next   = sum;
            rowstart_next = sum;
            col_next      = '0;
          end
          CH_RETURN: begin
            cursor_next = sum;
            col_next    = '0;
          end
          CH_BACKSPACE: begin
            if (col != '0) begin
              cursor_next = sum;
              col_next    = col - COLW'(1);
              we          = 1'b1;
              waddr       = AW'(sum);
              wdata       = CH_SPACE;
            end
          end
          default: begin
            we          = 1'b1;
            waddr       = AW'(cursor);
            wdata       = req_q.byte_value;
            cursor_next = sum;
            if (col == COL_LAST) begin
              col_next      = '0;
              rowstart_next = sum;
            end else begin
              col_next = col + COLW'(1);
            end
          end
        endcase

        if (past_end) begin
          cursor_next              = SCROLL_CUR;
          rowstart_next            = SCROLL_CUR;
          col_next                 = '0;
          idx_next                 = '0;
          wr_pend_next             = 1'b0;
          res_next.cursor_position = CURSOR_OUT_W'(SCROLL_CUR);
          res_next.read_character  = 8'h00;
          res_next.scrolled        = 1'b1;
          state_next               = ST_COPY;
        end else begin
          res_next.cursor_position = CURSOR_OUT_W'(cursor_next);
          res_next.read_character  = 8'h00;
          res_next.scrolled        = 1'b0;
          state_next               = ST_FINISH;
        end
      end

      // Move every row up: read one row ahead, write the previous cell.
      ST_COPY: begin
        raddr = AW'(sum);
        if (wr_pend) begin
          we    = 1'b1;
          waddr = wr_addr;
          wdata = rdata;
        end
        wr_addr_next = idx;
        wr_pend_next = 1'b1;
        if (idx == COPY_LAST) begin
          state_next = ST_DRAIN;
        end else begin
          idx_next = idx + AW'(1);
        end
      end

      // Write the last copied cell.
      ST_DRAIN: begin
        we           = 1'b1;
        waddr        = wr_addr;
        wdata        = rdata;
        wr_pend_next = 1'b0;
        idx_next     = BOTTOM_ROW;
        state_next   = ST_BLANK;
      end

      // Blank the bottom row.
      ST_BLANK: begin
        we = 1'b1;
        if (idx == LAST_CELL) begin
          idx_next   = '0;
          state_next = ST_FINISH;
        end else begin
          idx_next = idx + AW'(1);
        end
      end

      // Hold the result until the output register takes it.
      ST_FINISH: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      idx      <= '0;
      wr_pend  <= 1'b0;
      cursor   <= '0;
      rowstart <= '0;
      col      <= '0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      wr_pend  <= wr_pend_next;
      cursor   <= cursor_next;
      rowstart <= rowstart_next;
      col      <= col_next;
    end
    wr_addr <= wr_addr_next;
    req_q   <= req_q_next;
    res     <= res_next;
  end

`ifndef SYNTHESIS
  // The cursor always stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor < CW'(CELLS))
    else $error("cursor left the screen");

  // Cursor, row start and column agree.
  a_row_col: assert property (@(posedge clk) disable iff (rst)
    cursor == rowstart + CW'(col))
    else $error("cursor does not match row start plus column");

  // During the scroll copy the write never hits the cell being read.
  a_copy_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY && we) |-> (waddr != raddr))
    else $error("scroll copy wrote the cell being read");

  // A result not yet taken stays put.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !res_take) |=> (state == ST_FINISH && $stable(res)))
    else $error("pending result changed before it was taken");
`endif

endmodule

/* src/text_console_character_writer.sv */
// Top level of the text console character writer: request intake and output register.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_stall     command, byte_value, cell_address
//   out      out_valid / out_stall   cursor_position, read_character, scrolled
//
// A write request without scroll passes through the EXEC and FINISH steps and a read
// through the RD and FINISH steps of the sequencer around the single store port pair.
// A scroll adds the copy, drain and blank steps: one store cell moved or blanked per cycle.
// After reset the store is cleared to spaces; in_stall is high meanwhile.
// A finished result waits in the output register; the next request is taken
// meanwhile and its result waits in the sequencer if out_stall stays high.
module text_console_character_writer
  import tccw_pkg::*;
#(
  parameter int unsigned ROWS    = ROWS_DEFAULT,
  parameter int unsigned COLUMNS = COLUMNS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    command,
  input  logic [7:0]              byte_value,
  input  logic [ADDR_IN_W-1:0]    cell_address,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CURSOR_OUT_W-1:0] cursor_position,
  output logic [7:0]              read_character,
  output logic                    scrolled
);

  req_t req;
  res_t res;
  logic ready;
  logic start;
  logic res_valid;
  logic res_take;

  // Request intake.
  assign req.command      = command;
  assign req.byte_value   = byte_value;
  assign req.cell_address = cell_address;
  assign in_stall         = !ready;
  assign start            = in_valid && ready;

  tccw_engine #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .ready     (ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // The output register loads when empty or being emptied.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_take) begin
      cursor_position <= res.cursor_position;
      read_character  <= res.read_character;
      scrolled        <= res.scrolled;
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the text console character writer: random requests, predicted results.
module tb_top
  import tccw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROWS  = ROWS_DEFAULT;
  localparam int unsigned COLS  = COLUMNS_DEFAULT;
  localparam int unsigned CELLS = ROWS * COLS;

  localparam int TOTAL_ITEMS = 1950;
  // Idling stops once this few requests remain to be sent.
  localparam int CALM_TAIL = 150;
  // Every request scrolling, with full stalls and gaps, three times over.
  localparam int MAX_CYCLES = 3 * (TOTAL_ITEMS + 100) * (CELLS + 20);

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid     = 1'b0;
  logic                    in_stall;
  logic                    command      = CMD_WRITE;
  logic [7:0]              byte_value   = 8'h00;
  logic [ADDR_IN_W-1:0]    cell_address = '0;
  logic                    out_valid;
  logic                    out_stall    = 1'b0;
  logic [CURSOR_OUT_W-1:0] cursor_position;
  logic [7:0]              read_character;
  logic                    scrolled;

  text_console_character_writer #(
    .ROWS    (ROWS),
    .COLUMNS (COLS)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .byte_value      (byte_value),
    .cell_address    (cell_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cursor_position (cursor_position),
    .read_character  (read_character),
    .scrolled        (scrolled)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be sent and results predicted for accepted requests.
  req_t pending_requests[$];
  res_t predicted_results[$];

  // Shadow copy of the character store and cursor.
  logic [7:0]  screen_model [CELLS];
  int unsigned cursor_model;

  int error_count = 0;
  int cycle_count = 0;

  req_t sent_req;
  int   gap_left   = 0;
  int   gap_pct    = 0;
  int   stall_left = 0;
  int   stall_pct  = 0;

  // Apply one request to the shadow console and return the result it should give.
  function automatic res_t teletype_predict(req_t r);
    res_t        e;
    int unsigned cur;
    int unsigned col;
    e = '0;
    if (r.command == CMD_WRITE) begin
      cur = (cursor_model >= CELLS) ? CELLS - 1 : cursor_model;
      col = cur % COLS;
      case (r.byte_value)
        CH_NEWLINE: cur = cur - col + COLS;
        CH_RETURN:  cur = cur - col;
        CH_BACKSPACE: begin
          // Backspace does nothing at column zero.
          if (col != 0) begin
            cur = cur - 1;
            screen_model[cur] = CH_SPACE;
          end
        end
        default: begin
          screen_model[cur] = r.byte_value;
          cur = cur + 1;
        end
      endcase
      // Passing the last cell scrolls the screen up one row.
      if (cur >= CELLS) begin
        for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = CH_SPACE;
        cur = cur - COLS;
        e.scrolled = 1'b1;
      end
      cursor_model = cur;
    end else begin
      e.read_character = (r.cell_address < CELLS) ? screen_model[r.cell_address] : CH_SPACE;
    end
    e.cursor_position = CURSOR_OUT_W'(cursor_model);
    return e;
  endfunction

  task automatic queue_write(input logic [7:0] b);
    req_t r;
    r.command      = CMD_WRITE;
    r.byte_value   = b;
    r.cell_address = ADDR_IN_W'($urandom_range(2047));
    pending_requests.push_back(r);
  endtask

  task automatic queue_read(input int unsigned a);
    req_t r;
    r.command      = CMD_READ;
    r.byte_value   = 8'($urandom_range(255));
    r.cell_address = ADDR_IN_W'(a);
    pending_requests.push_back(r);
  endtask

  // Request driver: holds a request until it is taken, with random gaps between requests.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) predicted_results.push_back(teletype_predict(sent_req));
      if (cycle_count % 256 == 0) gap_pct = $urandom_range(3) * 15;
      if (!in_valid || !in_stall) begin
        if (gap_left == 0 && pending_requests.size() > CALM_TAIL &&
            $urandom_range(99) < gap_pct) gap_left = $urandom_range(5, 1);
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          sent_req = pending_requests.pop_front();
          in_valid     <= 1'b1;
          command      <= sent_req.command;
          byte_value   <= sent_req.byte_value;
          cell_address <= sent_req.cell_address;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random stall bursts, and each accepted result checked in order.
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with none predicted: cursor %0d char %02h scrolled %0d",
                   $time, cursor_position, read_character, scrolled);
          error_count++;
        end else begin
          exp_res = predicted_results.pop_front();
          if (cursor_position !== exp_res.cursor_position) begin
            $display("%0t: cursor_position expected %0d actual %0d",
                     $time, exp_res.cursor_position, cursor_position);
            error_count++;
          end
          if (read_character !== exp_res.read_character) begin
            $display("%0t: read_character expected %02h actual %02h",
                     $time, exp_res.read_character, read_character);
            error_count++;
          end
          if (scrolled !== exp_res.scrolled) begin
            $display("%0t: scrolled expected %0d actual %0d",
                     $time, exp_res.scrolled, scrolled);
            error_count++;
          end
        end
      end
      if (cycle_count % 256 == 128) stall_pct = $urandom_range(3) * 15;
      if (stall_left == 0 && pending_requests.size() > CALM_TAIL &&
          $urandom_range(99) < stall_pct) stall_left = $urandom_range(5, 1);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus, reset and end of test.
  initial begin
    int kind;
    int len;
    int pick;
    for (int i = 0; i < CELLS; i++) screen_model[i] = CH_SPACE;
    cursor_model = 0;

    // Directed: cleared store, reads past the screen, control bytes, backspace edges.
    queue_read(0);
    queue_read(CELLS - 1);
    queue_read(CELLS);
    queue_read(2047);
    queue_write(CH_BACKSPACE);
    queue_write(8'h41);
    queue_write(8'hFF);
    queue_write(8'h00);
    queue_write(8'h07);
    queue_write(CH_BACKSPACE);
    queue_write(CH_RETURN);
    queue_write(CH_BACKSPACE);
    queue_write(8'h5A);
    queue_read(0);
    queue_read(1);
    queue_read(2);
    queue_write(CH_NEWLINE);
    queue_write(8'h7E);
    queue_read(COLS);
    queue_read(2046);

    // Random: mostly text lines, newline runs and read-back, with some noise.
    while (pending_requests.size() < TOTAL_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // A line of text, sometimes exactly one row long, with the odd backspace.
        len = ($urandom_range(5) == 0) ? COLS : $urandom_range(100, 1);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(19) == 0) queue_write(CH_BACKSPACE);
          else queue_write(8'($urandom_range(8'h7E, 8'h20)));
        end
        pick = $urandom_range(9);
        if (pick < 7) queue_write(CH_NEWLINE);
        else if (pick < 8) queue_write(CH_RETURN);
      end else if (kind < 65) begin
        // Read back a few cells, mostly from the bottom rows where text lands.
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(99);
          if (pick < 60) queue_read($urandom_range(CELLS - 1, CELLS - 5 * COLS));
          else if (pick < 85) queue_read($urandom_range(CELLS - 1));
          else queue_read($urandom_range(2047, CELLS));
        end
      end else if (kind < 75) begin
        len = $urandom_range(30, 1);
        for (int i = 0; i < len; i++) queue_write(CH_NEWLINE);
      end else if (kind < 85) begin
        // Noise: every field random.
        len = $urandom_range(5, 1);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(1) == 0) queue_write(8'($urandom_range(255)));
          else queue_read($urandom_range(2047));
        end
      end else if (kind < 95) begin
        // Backspace run, often from the start of a row.
        if ($urandom_range(1) == 0) queue_write(CH_RETURN);
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) queue_write(CH_BACKSPACE);
      end else begin
        // Control bytes, most of them stored as ordinary characters.
        len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++) queue_write(8'($urandom_range(8'h1F)));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() > 0 || in_valid || predicted_results.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/tccw_pkg.sv
src/tccw_ram.sv
src/tccw_addr_unit.sv
src/tccw_engine.sv
src/text_console_character_writer.sv
tb/tb_top.sv
